[src/fte_pkg.sv]
package fte_pkg;

  // Fixed field widths of the item and result words.
  localparam int unsigned POS_W  = 11;
  localparam int unsigned PTR_W  = POS_W + 1;  // walk pointers reach up to twice the size
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SUM_W  = 32;

  localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

  // Register index decoded from paddr[2].
  localparam logic REG_SIZE_IN_USE = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 3'd0,
    FUNC_PREFIX = 3'd1,
    FUNC_RANGE  = 3'd2,
    FUNC_LOWER  = 3'd3,
    FUNC_UPPER  = 3'd4,
    FUNC_CLEAR  = 3'd5
  } fte_func_e;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_CLEAR     = 6'b000010,
    ST_WALK      = 6'b000100,
    ST_BND_ISSUE = 6'b001000,
    ST_BND_USE   = 6'b010000,
    ST_RESP      = 6'b100000
  } fte_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [POS_W-1:0]       position;
    logic [POS_W-1:0]       position_low;
    logic signed [VAL_W-1:0] value;
  } fte_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        index;
    logic                    error;
  } fte_out_t;

  // Compare flags of a subtraction a - b, both operands signed.
  typedef struct packed {
    logic b_lt_a;
    logic b_le_a;
  } fte_cmp_t;

  // Largest power of two not above n.
  function automatic logic [PTR_W-1:0] top_pow2(input logic [POS_W-1:0] n);
    logic [PTR_W-1:0] r;
    r = '0;
    for (int i = 0; i < POS_W; i++) begin
      if (n[i]) begin
        r = PTR_W'(1) << i;
      end
    end
    return r;
  endfunction

endpackage

[src/fte_node_ram.sv]
module fte_node_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[src/fte_alu.sv]
module fte_alu
  import fte_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] res_o,
  output fte_cmp_t         cmp_o
);

  logic [WIDTH:0] a_ext;
  logic [WIDTH:0] b_ext;
  logic [WIDTH:0] r_ext;

  // One extra bit keeps the signed difference exact.
  assign a_ext = {a_i[WIDTH-1], a_i};
  assign b_ext = {b_i[WIDTH-1], b_i};
  assign r_ext = sub_i ? (a_ext - b_ext) : (a_ext + b_ext);

  assign res_o        = r_ext[WIDTH-1:0];
  assign cmp_o.b_le_a = ~r_ext[WIDTH];
  assign cmp_o.b_lt_a = ~r_ext[WIDTH] & (|r_ext);

endmodule

[src/fenwick_tree_engine_core.sv]
// Words are taken one at a time through one node memory (one read and one write port) and
// one shared adder. The sequencer is idle, and takes the next word, once the output word
// is loaded; a stalled output word holds the sequencer in its response state.
// Reset: control state clears at once, then a clearing pass over every node address zeroes
// the node memory while no input word is taken; configuration writes are taken throughout.
module fenwick_tree_engine_core
  import fte_pkg::*;
#(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  fte_in_t     in_word_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output fte_out_t    out_word_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] size_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SIZE_IN_USE);
  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? 32'(size_q) : '0;

  // Effective size: zero acts as one, anything above DEPTH as DEPTH.
  logic [POS_W-1:0] n_eff;
  logic [PTR_W-1:0] n_ptr;

  always_comb begin
    if (size_q == '0) begin
      n_eff = POS_W'(1);
    end else if (32'(size_q) > DEPTH) begin
      n_eff = POS_W'(DEPTH);
    end else begin
      n_eff = size_q;
    end
  end

  assign n_ptr = PTR_W'(n_eff);

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  fte_state_e           state_q, state_d;
  logic [AW-1:0]        clr_cnt_q, clr_cnt_d;
  logic                 clr_reply_q, clr_reply_d;
  logic                 rvld_q, rvld_d;       // node read in flight, data next cycle
  logic                 out_vld_q, out_vld_d;

  fte_func_e            func_q, func_d;
  logic [PTR_W-1:0]     p_q, p_d;             // walk pointer
  logic [POS_W-1:0]     lo_q, lo_d;           // left end minus one for range sum
  logic                 phase_q, phase_d;     // second walk of a range sum subtracts
  logic                 two_q, two_d;
  logic [PTR_W-1:0]     wp_q, wp_d;           // node of the pending read
  logic [PTR_W-1:0]     x_q, x_d;             // bound search position
  logic [PTR_W-1:0]     step_q, step_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;       // sum accumulator, or remaining key
  logic [VALUE_WIDTH-1:0] val_q, val_d;       // amount to add
  logic                 err_q, err_d;
  fte_out_t             out_q, out_d;

  // Memory and shared unit hookup
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   rd_en;
  logic [PTR_W-1:0]       rd_node;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  logic [VALUE_WIDTH-1:0] alu_a;
  logic                   alu_sub;
  logic [VALUE_WIDTH-1:0] alu_res;
  fte_cmp_t               alu_cmp;

  fte_node_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (AW'(rd_node - PTR_W'(1))),
    .rdata_o (mem_rdata)
  );

  // Adder serves node update, prefix accumulation and key reduction in the bound search.
  fte_alu #(
    .WIDTH (VALUE_WIDTH)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (mem_rdata),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .cmp_o (alu_cmp)
  );

  assign alu_a   = (func_q == FUNC_ADD) ? val_q : acc_q;
  assign alu_sub = (state_q == ST_BND_USE) ? 1'b1 :
                   (func_q == FUNC_ADD)    ? 1'b0 : phase_q;

  // Walk helpers: lowest set bit of the pointer, and whether another node is due.
  logic [PTR_W-1:0] lowbit;
  logic             walk_more;
  logic [PTR_W-1:0] cand;

  assign lowbit    = p_q & (~p_q + PTR_W'(1));
  assign walk_more = (func_q == FUNC_ADD) ? (p_q <= n_ptr) : (p_q != '0);
  assign cand      = x_q + step_q;

  // Input range checks
  logic pos_bad;
  logic lo_bad;

  assign pos_bad = PTR_W'(in_word_i.position) > n_ptr;
  assign lo_bad  = (in_word_i.position_low == '0) ||
                   (PTR_W'(in_word_i.position_low) > (n_ptr + PTR_W'(1)));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    clr_reply_d = clr_reply_q;
    rvld_d      = rvld_q;
    out_vld_d   = out_vld_q;
    func_d      = func_q;
    p_d         = p_q;
    lo_d        = lo_q;
    phase_d     = phase_q;
    two_d       = two_q;
    wp_d        = wp_q;
    x_d         = x_q;
    step_d      = step_q;
    acc_d       = acc_q;
    val_d       = val_q;
    err_d       = err_q;
    out_d       = out_q;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    rd_en     = 1'b0;
    rd_node   = p_q;

    // Drop the output word once taken.
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = fte_func_e'(in_word_i.func);
          p_d     = PTR_W'(in_word_i.position);
          lo_d    = in_word_i.position_low - POS_W'(1);
          val_d   = VALUE_WIDTH'(in_word_i.value);
          acc_d   = '0;
          err_d   = 1'b0;
          x_d     = '0;
          phase_d = 1'b0;
          two_d   = 1'b0;
          rvld_d  = 1'b0;
          unique case (in_word_i.func)
            FUNC_ADD: begin
              if (in_word_i.position == '0 || pos_bad) begin
                err_d   = 1'b1;
                state_d = ST_RESP;
              end else begin
                state_d = ST_WALK;
              end
            end
            FUNC_PREFIX: begin
              if (pos_bad) begin
                err_d   = 1'b1;
                state_d = ST_RESP;
              end else begin
                state_d = ST_WALK;
              end
            end
            FUNC_RANGE: begin
              if (pos_bad || lo_bad) begin
                err_d   = 1'b1;
                state_d = ST_RESP;
              end else begin
                two_d   = 1'b1;
                state_d = ST_WALK;
              end
            end
            FUNC_LOWER, FUNC_UPPER: begin
              acc_d   = VALUE_WIDTH'(in_word_i.value);
              step_d  = top_pow2(n_eff);
              state_d = ST_BND_ISSUE;
            end
            FUNC_CLEAR: begin
              clr_cnt_d   = '0;
              clr_reply_d = 1'b1;
              state_d     = ST_CLEAR;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        if (clr_cnt_q == LAST_ADDR) begin
          state_d = clr_reply_q ? ST_RESP : ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end

      ST_WALK: begin
        // Retire the read issued last cycle.
        if (rvld_q) begin
          if (func_q == FUNC_ADD) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(wp_q - PTR_W'(1));
            mem_wdata = alu_res;
          end else begin
            acc_d = alu_res;
          end
        end
        // Issue the next node; addresses do not depend on data, so reads overlap.
        if (walk_more) begin
          rd_en  = 1'b1;
          rvld_d = 1'b1;
          wp_d   = p_q;
          p_d    = (func_q == FUNC_ADD) ? (p_q + lowbit) : (p_q - lowbit);
        end else begin
          rvld_d = 1'b0;
          if (!rvld_q) begin
            if (two_q && !phase_q) begin
              phase_d = 1'b1;
              p_d     = PTR_W'(lo_q);
            end else begin
              state_d = ST_RESP;
            end
          end
        end
      end

      ST_BND_ISSUE: begin
        if (step_q == '0) begin
          state_d = ST_RESP;
        end else if (cand <= n_ptr) begin
          rd_en   = 1'b1;
          rd_node = cand;
          wp_d    = cand;
          state_d = ST_BND_USE;
        end else begin
          step_d = step_q >> 1;
        end
      end

      ST_BND_USE: begin
        // Take the node when it stays below the key (or equal for upper bound).
        if ((func_q == FUNC_UPPER) ? alu_cmp.b_le_a : alu_cmp.b_lt_a) begin
          x_d   = wp_q;
          acc_d = alu_res;
        end
        step_d  = step_q >> 1;
        state_d = ST_BND_ISSUE;
      end

      ST_RESP: begin
        // Hold until the output register is free.
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d   = 1'b1;
          out_d.sum   = (func_q == FUNC_PREFIX || func_q == FUNC_RANGE) ?
                        SUM_W'(acc_q) : '0;
          out_d.index = (func_q == FUNC_LOWER || func_q == FUNC_UPPER) ?
                        POS_W'(x_q + PTR_W'(1)) : '0;
          out_d.error = err_q;
          clr_reply_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_reply_q <= 1'b0;
      rvld_q      <= 1'b0;
      out_vld_q   <= 1'b0;
      size_q      <= SIZE_RESET;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_reply_q <= clr_reply_d;
      rvld_q      <= rvld_d;
      out_vld_q   <= out_vld_d;
      if (cfg_we) begin
        size_q <= pwdata[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    p_q     <= p_d;
    lo_q    <= lo_d;
    phase_q <= phase_d;
    two_q   <= two_d;
    wp_q    <= wp_d;
    x_q     <= x_d;
    step_q  <= step_d;
    acc_q   <= acc_d;
    val_q   <= val_d;
    err_q   <= err_d;
    out_q   <= out_d;
  end

`ifndef ASSERT_OFF
  // Only the clearing pass and an add walk may write the node memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != ST_CLEAR) |-> (state_q == ST_WALK && func_q == FUNC_ADD))
    else $error("node memory written outside clear or add walk");

  // A walk never reads node zero or a node beyond the effective size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && state_q == ST_WALK) |-> (rd_node != '0 && rd_node <= n_ptr))
    else $error("walk read outside tree");

  // A new output word only comes from the response state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_RESP))
    else $error("output word loaded outside response");

  // An accepted word always starts work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted word left sequencer idle");
`endif

endmodule
